>>> rtl/bdgr_pkg.sv
// shared types, constants and the arm lookup table of the glyph rasterizer
package bdgr_pkg;

  localparam int CODE_W  = 21;
  localparam int ROW_W   = 64;
  localparam int ROWN_W  = 6;
  localparam int DIM_W   = 7;
  localparam int DPI_W   = 10;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [CODE_W-1:0] FIRST_CODE  = 21'h2500;
  localparam logic [CODE_W-1:0] LIGHT_CROSS = 21'h253c;
  localparam logic [CODE_W-1:0] HEAVY_CROSS = 21'h254b;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DPI         = 2'd2;

  // arm kinds
  localparam logic [1:0] ARM_NONE  = 2'd0;
  localparam logic [1:0] ARM_LIGHT = 2'd1;
  localparam logic [1:0] ARM_HEAVY = 2'd2;

  // arm slots inside an arm byte
  localparam int ARM_LEFT  = 0;
  localparam int ARM_RIGHT = 1;
  localparam int ARM_UP    = 2;
  localparam int ARM_DOWN  = 3;

  typedef struct packed {
    logic [DIM_W-1:0] glyph_width;
    logic [DIM_W-1:0] glyph_height;
    logic [DPI_W-1:0] dots_per_inch;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] x1;
    logic [DIM_W-1:0] y0;
    logic [DIM_W-1:0] y1;
  } rect_t;

  typedef struct packed {
    rect_t [3:0]      rects;
    logic [DIM_W-1:0] height;
  } desc_t;

  function automatic logic [7:0] mk_arms(input int l, input int r, input int u, input int d);
    mk_arms = {d[1:0], u[1:0], r[1:0], l[1:0]};
  endfunction

  // arms of codepoint FIRST_CODE + off, zero for blank glyphs
  function automatic logic [7:0] arm_lookup(input logic [6:0] off);
    logic [7:0] a;
    a = 8'd0;
    case (off)
      7'h00: a = mk_arms(1, 1, 0, 0);
      7'h01: a = mk_arms(2, 2, 0, 0);
      7'h02: a = mk_arms(0, 0, 1, 1);
      7'h03: a = mk_arms(0, 0, 2, 2);
      7'h0c: a = mk_arms(0, 1, 0, 1);
      7'h0d: a = mk_arms(0, 2, 0, 1);
      7'h0e: a = mk_arms(0, 1, 0, 2);
      7'h0f: a = mk_arms(0, 2, 0, 2);
      7'h10: a = mk_arms(1, 0, 0, 1);
      7'h11: a = mk_arms(2, 0, 0, 1);
      7'h12: a = mk_arms(1, 0, 0, 2);
      7'h13: a = mk_arms(2, 0, 0, 2);
      7'h14: a = mk_arms(0, 1, 1, 0);
      7'h15: a = mk_arms(0, 2, 1, 0);
      7'h16: a = mk_arms(0, 1, 2, 0);
      7'h17: a = mk_arms(0, 2, 2, 0);
      7'h18: a = mk_arms(1, 0, 1, 0);
      7'h19: a = mk_arms(2, 0, 1, 0);
      7'h1a: a = mk_arms(1, 0, 2, 0);
      7'h1b: a = mk_arms(2, 0, 2, 0);
      7'h1c: a = mk_arms(0, 1, 1, 1);
      7'h1d: a = mk_arms(0, 2, 1, 1);
      7'h1e: a = mk_arms(0, 1, 2, 1);
      7'h1f: a = mk_arms(0, 1, 1, 2);
      7'h20: a = mk_arms(0, 1, 2, 2);
      7'h21: a = mk_arms(0, 2, 2, 1);
      7'h22: a = mk_arms(0, 2, 1, 2);
      7'h23: a = mk_arms(0, 2, 2, 2);
      7'h24: a = mk_arms(1, 0, 1, 1);
      7'h25: a = mk_arms(2, 0, 1, 1);
      7'h26: a = mk_arms(1, 0, 2, 1);
      7'h27: a = mk_arms(1, 0, 1, 2);
      7'h28: a = mk_arms(1, 0, 2, 2);
      7'h29: a = mk_arms(2, 0, 2, 1);
      7'h2a: a = mk_arms(2, 0, 1, 2);
      7'h2b: a = mk_arms(2, 0, 2, 2);
      7'h2c: a = mk_arms(1, 1, 0, 1);
      7'h2d: a = mk_arms(2, 1, 0, 1);
      7'h2e: a = mk_arms(1, 2, 0, 1);
      7'h2f: a = mk_arms(2, 2, 0, 1);
      7'h30: a = mk_arms(1, 1, 0, 2);
      7'h31: a = mk_arms(2, 1, 0, 2);
      7'h32: a = mk_arms(1, 2, 0, 2);
      7'h33: a = mk_arms(2, 2, 0, 2);
      7'h34: a = mk_arms(1, 1, 1, 0);
      7'h35: a = mk_arms(2, 1, 1, 0);
      7'h36: a = mk_arms(1, 2, 1, 0);
      7'h37: a = mk_arms(2, 2, 1, 0);
      7'h38: a = mk_arms(1, 1, 2, 0);
      7'h39: a = mk_arms(2, 1, 2, 0);
      7'h3a: a = mk_arms(1, 2, 2, 0);
      7'h3b: a = mk_arms(2, 2, 2, 0);
      7'h3c: a = mk_arms(1, 1, 1, 1);
      7'h4b: a = mk_arms(2, 2, 2, 2);
      default: a = 8'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/bdgr_if.sv
// valid/ready channels for codepoints in and glyph rows out
interface bdgr_code_if;
  logic                         valid;
  logic                         ready;
  logic [bdgr_pkg::CODE_W-1:0]  codepoint;

  modport source (output valid, output codepoint, input ready);
  modport sink   (input valid, input codepoint, output ready);
endinterface

interface bdgr_row_if;
  logic                         valid;
  logic                         ready;
  logic [bdgr_pkg::ROW_W-1:0]   row_bits;
  logic [bdgr_pkg::ROWN_W-1:0]  row_number;
  logic                         last_row;

  modport source (output valid, output row_bits, output row_number, output last_row,
                  input ready);
  modport sink   (input valid, input row_bits, input row_number, input last_row,
                  output ready);
endinterface

>>> rtl/box_drawing_glyph_rasterizer_core.sv
// Box-drawing glyph rasterizer: each codepoint taken on the codes channel comes
// back as one item per pixel row on the rows channel, top row first, with
// last_row set on the final one; a glyph has glyph_height rows (1 to 64), sent at
// one row per cycle unless stalled, the back-end row generator's pace, and glyphs
// follow each other with no gap. The first row passes the front-end register, the
// queue and the output register. The front end (arm lookup and rectangle setup)
// runs ahead of the back end through a two-entry queue, so codepoints keep being
// taken while rows drain. Registers on the APB port: 0x0 glyph_width, 0x4
// glyph_height, 0x8 dots_per_inch; write them only while no glyph is in flight.
module box_drawing_glyph_rasterizer_core #(
  parameter int MAX_CELL_WIDTH  = 64,
  parameter int MAX_CELL_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  bdgr_code_if.sink                     codes,
  bdgr_row_if.source                    rows,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdgr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdgr_pkg::DATA_W-1:0]   pwdata,
  output logic [bdgr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bdgr_pkg::*;

  cfg_t  cfg;
  logic  cfg_wr;

  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;
  logic  head_valid;
  logic  head_pop;
  desc_t head_desc;

  // register file, writes land on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width   <= DIM_W'(8);
      cfg.glyph_height  <= DIM_W'(16);
      cfg.dots_per_inch <= DPI_W'(96);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CELL_WIDTH:  cfg.glyph_width   <= pwdata[DIM_W-1:0];
        REG_CELL_HEIGHT: cfg.glyph_height  <= pwdata[DIM_W-1:0];
        REG_DPI:         cfg.dots_per_inch <= pwdata[DPI_W-1:0];
        default: ;  // unmapped address, dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CELL_WIDTH:  prdata = DATA_W'(cfg.glyph_width);
      REG_CELL_HEIGHT: prdata = DATA_W'(cfg.glyph_height);
      REG_DPI:         prdata = DATA_W'(cfg.dots_per_inch);
      default:         prdata = '0;
    endcase
  end

  // front: classify the codepoint and set up the arm rectangles
  bdgr_front #(
    .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
    .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .codes      (codes),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  // glyph descriptors waiting for the row sweep
  bdgr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_desc   (head_desc)
  );

  // back: one row per cycle into the output register, unless the row stream stalls
  bdgr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (head_pop),
    .rows       (rows)
  );

endmodule

>>> rtl/bdgr_front.sv
// front end: takes codepoints, looks up arms and works out the four arm rectangles
module bdgr_front #(
  parameter int MAX_CELL_WIDTH  = 64,
  parameter int MAX_CELL_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  bdgr_code_if.sink         codes,
  input  bdgr_pkg::cfg_t    cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output bdgr_pkg::desc_t   push_desc
);
  import bdgr_pkg::*;

  logic              f_valid;
  logic              f_valid_next;
  logic [7:0]        f_arms;
  logic [7:0]        in_arms;
  logic [CODE_W-1:0] code_off;
  logic              in_block;

  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [4:0]        light;
  logic [4:0]        heavy;
  logic              multi_heavy;
  logic [4:0]        thick   [4];
  logic [4:0]        cross_w [4];
  logic [1:0]        kind    [4];
  logic signed [7:0] ws;
  logic signed [7:0] hs;
  logic signed [7:0] lx1, ry0, ly0, uy1, ux0, dx0, dy0, rx0;

  // floor(y/9) for y < 256
  function automatic logic [4:0] div9(input logic [7:0] y);
    logic [13:0] p;
    p = 14'(y) * 14'd57;
    return p[13:9];
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [7:0] half(input logic signed [7:0] v);
    logic signed [7:0] t;
    t = v + 8'(v[7]);
    return t >>> 1;
  endfunction

  function automatic logic [DIM_W-1:0] clip(input logic signed [7:0] v,
                                            input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({1'b0, lim})) begin
      r = lim;
    end else begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [7:0] sx(input logic [4:0] t);
    return $signed({3'b000, t});
  endfunction

  // classify on the way in
  assign code_off = codes.codepoint - FIRST_CODE;
  assign in_block = (codes.codepoint >= FIRST_CODE) && (codes.codepoint <= HEAVY_CROSS);
  assign in_arms  = in_block ? arm_lookup(code_off[6:0]) : 8'd0;

  assign codes.ready = !f_valid || push_ready;
  assign push_valid  = f_valid;

  always_comb begin
    f_valid_next = f_valid;
    if (codes.valid && codes.ready) begin
      f_valid_next = 1'b1;
    end else if (push_ready) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (codes.valid && codes.ready) begin
      f_arms <= in_arms;
    end
  end

  // geometry from the registered arms
  always_comb begin
    if (cfg.glyph_width == '0) begin
      w = DIM_W'(1);
    end else if (cfg.glyph_width > DIM_W'(MAX_CELL_WIDTH)) begin
      w = DIM_W'(MAX_CELL_WIDTH);
    end else begin
      w = cfg.glyph_width;
    end
    if (cfg.glyph_height == '0) begin
      h = DIM_W'(1);
    end else if (cfg.glyph_height > DIM_W'(MAX_CELL_HEIGHT)) begin
      h = DIM_W'(MAX_CELL_HEIGHT);
    end else begin
      h = cfg.glyph_height;
    end
  end

  assign light = div9({1'b0, cfg.dots_per_inch[9:3]});
  assign heavy = div9(cfg.dots_per_inch[9:2]);
  assign ws    = $signed({1'b0, w});
  assign hs    = $signed({1'b0, h});

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      kind[a] = f_arms[2*a +: 2];
    end
    multi_heavy = ($countones({kind[0] == ARM_HEAVY, kind[1] == ARM_HEAVY,
                               kind[2] == ARM_HEAVY, kind[3] == ARM_HEAVY}) > 1);
    for (int a = 0; a < 4; a++) begin
      thick[a]   = (kind[a] == ARM_HEAVY) ? heavy : light;
      cross_w[a] = (kind[a] == ARM_HEAVY && multi_heavy) ? heavy : light;
    end
  end

  assign lx1 = half(ws - sx(cross_w[ARM_LEFT])) + sx(cross_w[ARM_LEFT]);
  assign ly0 = half(hs - sx(thick[ARM_LEFT]));
  assign rx0 = half(ws - sx(cross_w[ARM_RIGHT]));
  assign ry0 = half(hs - sx(thick[ARM_RIGHT]));
  assign ux0 = half(ws - sx(thick[ARM_UP]));
  assign uy1 = half(hs - sx(cross_w[ARM_UP])) + sx(cross_w[ARM_UP]);
  assign dx0 = half(ws - sx(thick[ARM_DOWN]));
  assign dy0 = half(hs - sx(cross_w[ARM_DOWN]));

  always_comb begin
    push_desc.height = h;

    push_desc.rects[ARM_LEFT].en  = (kind[ARM_LEFT] != ARM_NONE);
    push_desc.rects[ARM_LEFT].x0  = '0;
    push_desc.rects[ARM_LEFT].x1  = clip(lx1, w);
    push_desc.rects[ARM_LEFT].y0  = clip(ly0, h);
    push_desc.rects[ARM_LEFT].y1  = clip(ly0 + sx(thick[ARM_LEFT]), h);

    push_desc.rects[ARM_RIGHT].en = (kind[ARM_RIGHT] != ARM_NONE);
    push_desc.rects[ARM_RIGHT].x0 = clip(rx0, w);
    push_desc.rects[ARM_RIGHT].x1 = w;
    push_desc.rects[ARM_RIGHT].y0 = clip(ry0, h);
    push_desc.rects[ARM_RIGHT].y1 = clip(ry0 + sx(thick[ARM_RIGHT]), h);

    push_desc.rects[ARM_UP].en    = (kind[ARM_UP] != ARM_NONE);
    push_desc.rects[ARM_UP].x0    = clip(ux0, w);
    push_desc.rects[ARM_UP].x1    = clip(ux0 + sx(thick[ARM_UP]), w);
    push_desc.rects[ARM_UP].y0    = '0;
    push_desc.rects[ARM_UP].y1    = clip(uy1, h);

    push_desc.rects[ARM_DOWN].en  = (kind[ARM_DOWN] != ARM_NONE);
    push_desc.rects[ARM_DOWN].x0  = clip(dx0, w);
    push_desc.rects[ARM_DOWN].x1  = clip(dx0 + sx(thick[ARM_DOWN]), w);
    push_desc.rects[ARM_DOWN].y0  = clip(dy0, h);
    push_desc.rects[ARM_DOWN].y1  = h;
  end

endmodule

>>> rtl/bdgr_queue.sv
// two-entry glyph descriptor queue between front and back
module bdgr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  bdgr_pkg::desc_t  push_desc,
  output logic             pop_valid,
  input  logic             pop,
  output bdgr_pkg::desc_t  pop_desc
);
  import bdgr_pkg::*;

  desc_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_desc   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 2'd1;
    end else if (do_pop && !do_push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

endmodule

>>> rtl/bdgr_back.sv
// back end: sweeps the rows of the head glyph into the output register
module bdgr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  bdgr_pkg::desc_t  head_desc,
  output logic             pop,
  bdgr_row_if.source       rows
);
  import bdgr_pkg::*;

  logic [ROWN_W-1:0] row;
  logic [ROWN_W-1:0] row_next;
  logic              o_valid;
  logic              o_valid_next;
  logic              advance;
  logic              fire;
  logic              is_last;
  logic [ROW_W-1:0]  bits;
  logic [DIM_W-1:0]  row_ext;

  // ones in bits [n-1:0], n up to 64
  function automatic logic [ROW_W-1:0] low_mask(input logic [DIM_W-1:0] n);
    logic [ROW_W-1:0] m;
    if (n[DIM_W-1]) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << n[DIM_W-2:0]) - ROW_W'(1);
    end
    return m;
  endfunction

  assign advance = !o_valid || rows.ready;
  assign fire    = advance && head_valid;
  assign row_ext = {1'b0, row};
  assign is_last = (row_ext == head_desc.height - DIM_W'(1));
  assign pop     = fire && is_last;

  always_comb begin
    bits = '0;
    for (int a = 0; a < 4; a++) begin
      if (head_desc.rects[a].en && row_ext >= head_desc.rects[a].y0 &&
          row_ext < head_desc.rects[a].y1) begin
        bits = bits | (low_mask(head_desc.rects[a].x1) & ~low_mask(head_desc.rects[a].x0));
      end
    end
  end

  always_comb begin
    row_next     = row;
    o_valid_next = o_valid;
    if (advance) begin
      o_valid_next = head_valid;
    end
    if (fire) begin
      row_next = is_last ? '0 : row + ROWN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      o_valid <= 1'b0;
    end else begin
      row     <= row_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rows.row_bits   <= bits;
      rows.row_number <= row;
      rows.last_row   <= is_last;
    end
  end

  assign rows.valid = o_valid;

endmodule

>>> rtl/bdgr_checker.sv
// port-level checks on the row stream, bound to the top level
module bdgr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          row_valid,
  input logic                          row_ready,
  input logic [bdgr_pkg::ROW_W-1:0]    row_bits,
  input logic [bdgr_pkg::ROWN_W-1:0]   row_number,
  input logic                          last_row
);
  import bdgr_pkg::*;

  // stalled row holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_ready |=> row_valid && $stable(row_bits) && $stable(row_number) &&
                               $stable(last_row))
    else $error("stalled row changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !row_valid)
    else $error("row valid right after reset");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_ready && !last_row |=>
      !row_valid || row_number == ROWN_W'($past(row_number) + ROWN_W'(1)))
    else $error("row number skipped");

  a_new_glyph: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_ready && last_row |=> !row_valid || row_number == '0)
    else $error("glyph does not start at row zero");

  a_max_rows: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_number == '1 |-> last_row)
    else $error("row 63 not marked last");

endmodule

bind box_drawing_glyph_rasterizer_core bdgr_checker u_bdgr_checker (
  .clk        (clk),
  .rst        (rst),
  .row_valid  (rows.valid),
  .row_ready  (rows.ready),
  .row_bits   (rows.row_bits),
  .row_number (rows.row_number),
  .last_row   (rows.last_row)
);

>>> tb/bdgr_glyph_checker.sv
// checker of the glyph rasterizer: predicts the rows of every codepoint taken and compares them
module bdgr_glyph_checker #(
  parameter int MAX_CELL_WIDTH  = 64,
  parameter int MAX_CELL_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          code_valid,
  input  logic                          code_ready,
  input  logic [bdgr_pkg::CODE_W-1:0]   codepoint,
  input  logic                          row_valid,
  input  logic                          row_ready,
  input  logic [bdgr_pkg::ROW_W-1:0]    row_bits,
  input  logic [bdgr_pkg::ROWN_W-1:0]   row_number,
  input  logic                          last_row,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [bdgr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdgr_pkg::DATA_W-1:0]   pwdata,
  input  logic [bdgr_pkg::DATA_W-1:0]   prdata,
  output int                            rows_pending,
  output int                            fail_count
);
  import bdgr_pkg::*;

  localparam int PTS_PER_INCH = 72;

  typedef struct packed {
    logic [ROW_W-1:0]  bits;
    logic [ROWN_W-1:0] num;
    logic              last;
  } glyph_row_t;

  glyph_row_t        rows_due [$];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [DPI_W-1:0]  dpi_reg;

  // arms as four nibbles: left, right, up, down from the top; 0 none, 1 light, 2 heavy
  function automatic logic [15:0] arm_digits(input logic [CODE_W-1:0] cp);
    int off;
    logic [15:0] d;
    d = 16'h0000;
    off = int'(cp) - int'(FIRST_CODE);
    if (cp >= FIRST_CODE && cp <= HEAVY_CROSS) begin
      case (off)
        'h00: d = 16'h1100;  'h01: d = 16'h2200;  'h02: d = 16'h0011;  'h03: d = 16'h0022;
        'h0c: d = 16'h0101;  'h0d: d = 16'h0201;  'h0e: d = 16'h0102;  'h0f: d = 16'h0202;
        'h10: d = 16'h1001;  'h11: d = 16'h2001;  'h12: d = 16'h1002;  'h13: d = 16'h2002;
        'h14: d = 16'h0110;  'h15: d = 16'h0210;  'h16: d = 16'h0120;  'h17: d = 16'h0220;
        'h18: d = 16'h1010;  'h19: d = 16'h2010;  'h1a: d = 16'h1020;  'h1b: d = 16'h2020;
        'h1c: d = 16'h0111;  'h1d: d = 16'h0211;  'h1e: d = 16'h0121;  'h1f: d = 16'h0112;
        'h20: d = 16'h0122;  'h21: d = 16'h0221;  'h22: d = 16'h0212;  'h23: d = 16'h0222;
        'h24: d = 16'h1011;  'h25: d = 16'h2011;  'h26: d = 16'h1021;  'h27: d = 16'h1012;
        'h28: d = 16'h1022;  'h29: d = 16'h2021;  'h2a: d = 16'h2012;  'h2b: d = 16'h2022;
        'h2c: d = 16'h1101;  'h2d: d = 16'h2101;  'h2e: d = 16'h1201;  'h2f: d = 16'h2201;
        'h30: d = 16'h1102;  'h31: d = 16'h2102;  'h32: d = 16'h1202;  'h33: d = 16'h2202;
        'h34: d = 16'h1110;  'h35: d = 16'h2110;  'h36: d = 16'h1210;  'h37: d = 16'h2210;
        'h38: d = 16'h1120;  'h39: d = 16'h2120;  'h3a: d = 16'h1220;  'h3b: d = 16'h2220;
        'h3c: d = 16'h1111;  'h4b: d = 16'h2222;
        default: d = 16'h0000;
      endcase
    end
    return d;
  endfunction

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int max);
    if (v < 1)
      return 1;
    if (int'(v) > max)
      return max;
    return int'(v);
  endfunction

  // pixels of row y of the glyph of cp in a w x h cell
  function automatic logic [ROW_W-1:0] glyph_row(input logic [CODE_W-1:0] cp, input int y,
                                                 input int w, input int h, input int dpi);
    logic [15:0]      digits;
    logic [1:0]       kind [4];
    logic [ROW_W-1:0] bits;
    int               light, heavy, heavies, th, cr, x0, x1, y0, y1;
    digits  = arm_digits(cp);
    light   = dpi / PTS_PER_INCH;
    heavy   = 2 * dpi / PTS_PER_INCH;
    heavies = 0;
    bits    = '0;
    for (int a = 0; a < 4; a++) begin
      kind[a] = digits[13 - 4*a -: 2];
      if (kind[a] == ARM_HEAVY)
        heavies++;
    end
    for (int a = 0; a < 4; a++) begin
      if (kind[a] != ARM_NONE) begin
        th = (kind[a] == ARM_HEAVY) ? heavy : light;
        // a lone heavy arm crosses only a light stroke
        cr = (kind[a] == ARM_HEAVY && heavies > 1) ? heavy : light;
        case (a)
          ARM_LEFT: begin
            x0 = 0;               x1 = (w - cr) / 2 + cr;
            y0 = (h - th) / 2;    y1 = y0 + th;
          end
          ARM_RIGHT: begin
            x0 = (w - cr) / 2;    x1 = w;
            y0 = (h - th) / 2;    y1 = y0 + th;
          end
          ARM_UP: begin
            x0 = (w - th) / 2;    x1 = x0 + th;
            y0 = 0;               y1 = (h - cr) / 2 + cr;
          end
          default: begin
            x0 = (w - th) / 2;    x1 = x0 + th;
            y0 = (h - cr) / 2;    y1 = h;
          end
        endcase
        if (x0 < 0) x0 = 0;
        if (x1 > w) x1 = w;
        if (y0 < 0) y0 = 0;
        if (y1 > h) y1 = h;
        if (y >= y0 && y < y1) begin
          for (int x = x0; x < x1; x++)
            bits[x] = 1'b1;
        end
      end
    end
    return bits;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: saw %h, wanted %h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    glyph_row_t       want;
    glyph_row_t       entry;
    int               w, h;
    logic [DATA_W-1:0] reg_val;
    if (rst) begin
      width_reg  = DIM_W'(8);
      height_reg = DIM_W'(16);
      dpi_reg    = DPI_W'(96);
      rows_due.delete();
      fail_count   = 0;
      rows_pending = 0;
    end else begin
      if (code_valid && code_ready) begin
        w = clamp_dim(width_reg, MAX_CELL_WIDTH);
        h = clamp_dim(height_reg, MAX_CELL_HEIGHT);
        for (int y = 0; y < h; y++) begin
          entry.bits = glyph_row(codepoint, y, w, h, int'(dpi_reg));
          entry.num  = ROWN_W'(y);
          entry.last = (y == h - 1);
          rows_due.push_back(entry);
        end
      end
      if (row_valid && row_ready) begin
        if (rows_due.size() == 0) begin
          report_mismatch("row with none due", row_bits, '0);
        end else begin
          want = rows_due.pop_front();
          if (row_bits !== want.bits)
            report_mismatch($sformatf("row_bits of row %0d", want.num), row_bits, want.bits);
          if (row_number !== want.num)
            report_mismatch("row_number", 64'(row_number), 64'(want.num));
          if (last_row !== want.last)
            report_mismatch($sformatf("last_row of row %0d", want.num),
                            64'(last_row), 64'(want.last));
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_CELL_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
            REG_CELL_HEIGHT: height_reg = pwdata[DIM_W-1:0];
            REG_DPI:         dpi_reg    = pwdata[DPI_W-1:0];
            default: ;
          endcase
        end else if (paddr[ADDR_W-1:2] != 2'd3) begin
          case (paddr[ADDR_W-1:2])
            REG_CELL_WIDTH:  reg_val = DATA_W'(width_reg);
            REG_CELL_HEIGHT: reg_val = DATA_W'(height_reg);
            default:         reg_val = DATA_W'(dpi_reg);
          endcase
          if (prdata !== reg_val)
            report_mismatch($sformatf("read of 0x%h", paddr), 64'(prdata), 64'(reg_val));
        end
      end
      rows_pending = rows_due.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// top of the glyph rasterizer testbench: clock, reset, stimulus, register setup and verdict
module tb_top;
  import bdgr_pkg::*;

  // quiet cycles tolerated before the run is declared hung
  localparam int WATCHDOG_LIMIT = 5000;
  // length of the long receiver hold-off that backs up the block
  localparam int HOLD_CYCLES    = 400;
  // cycles to wait after the last row
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [ADDR_W-1:0] ADDR_CELL_WIDTH  = {REG_CELL_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_CELL_HEIGHT = {REG_CELL_HEIGHT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_DPI         = {REG_DPI, 2'b00};
  // no register lives here, writes must be dropped
  localparam logic [ADDR_W-1:0] ADDR_UNUSED      = 4'hc;

  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int rows_pending;
  int fail_count;
  int quiet_cycles;
  int sender_idle_pct;
  int recv_stall_pct;
  bit hold_off_req;

  // hand-picked codepoints: every arm shape class, the blank holes, the cross pair,
  // the block edges and codepoints far outside the block
  logic [CODE_W-1:0] probe_codes [0:24] = '{
    21'h002500, 21'h002501, 21'h002502, 21'h002503, 21'h002504, 21'h00250b,
    21'h00250c, 21'h00250d, 21'h00250e, 21'h00250f, 21'h00251c, 21'h002523,
    21'h00252b, 21'h002533, 21'h00253b, 21'h00253c, 21'h00253d, 21'h00254a,
    21'h00254b, 21'h00254c, 21'h00259f, 21'h0025a0, 21'h0024ff, 21'h000000,
    21'h10ffff
  };

  bdgr_code_if code_ch ();
  bdgr_row_if  row_ch ();

  box_drawing_glyph_rasterizer_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .codes   (code_ch),
    .rows    (row_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bdgr_glyph_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .code_valid   (code_ch.valid),
    .code_ready   (code_ch.ready),
    .codepoint    (code_ch.codepoint),
    .row_valid    (row_ch.valid),
    .row_ready    (row_ch.ready),
    .row_bits     (row_ch.row_bits),
    .row_number   (row_ch.row_number),
    .last_row     (row_ch.last_row),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .rows_pending (rows_pending),
    .fail_count   (fail_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: any accepted item on either channel restarts the count
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((code_ch.valid && code_ch.ready) || (row_ch.valid && row_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // row receiver: random stalls at the current rate, or one long hold-off on request
  initial begin
    row_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        row_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        row_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
        @(negedge clk);
      end
    end
  end

  // offer one codepoint, with random idle cycles ahead of it; returns at a falling edge
  task automatic offer_code(input logic [CODE_W-1:0] cp);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      code_ch.valid <= 1'b0;
      @(negedge clk);
    end
    code_ch.valid     <= 1'b1;
    code_ch.codepoint <= cp;
    @(posedge clk);
    while (!code_ch.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // mostly drawable glyphs, some blank holes of the block, some anything at all
  function automatic logic [CODE_W-1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70)
      return FIRST_CODE + CODE_W'($urandom_range(0, 'h4b));
    if (sel < 85)
      return FIRST_CODE + CODE_W'($urandom_range('h4c, 'h9f));
    return CODE_W'($urandom_range(0, 1114111));
  endfunction

  // stop offering and let every due row come out, then a few spare cycles
  task automatic drain_rows(input int spare);
    code_ch.valid <= 1'b0;
    @(negedge clk);
    while (rows_pending != 0)
      @(negedge clk);
    repeat (spare) @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // write a register with junk above its width, which the block must ignore
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input int value, input int bits);
    logic [DATA_W-1:0] junk;
    junk = $urandom();
    apb_access(1'b1, addr, (junk & ~((DATA_W'(1) << bits) - 1)) | DATA_W'(value));
  endtask

  task automatic set_idle(input int phase);
    case (phase)
      IDLE_SENDER:   begin sender_idle_pct = 79; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 79; end
      IDLE_BOTH:     begin sender_idle_pct = 20; recv_stall_pct = 20; end
      default:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // one setting of the registers and a run of random glyphs under it;
  // squeeze adds the long receiver hold-off and a full drain halfway through
  task automatic run_batch(input int w, input int h, input int dpi, input int count,
                           input int phase, input bit squeeze);
    drain_rows(8);
    write_reg(ADDR_CELL_WIDTH, w, DIM_W);
    write_reg(ADDR_CELL_HEIGHT, h, DIM_W);
    write_reg(ADDR_DPI, dpi, DPI_W);
    write_reg(ADDR_UNUSED, int'($urandom_range(0, 1023)), DPI_W);
    apb_access(1'b0, ADDR_CELL_WIDTH, '0);
    apb_access(1'b0, ADDR_CELL_HEIGHT, '0);
    apb_access(1'b0, ADDR_DPI, '0);
    set_idle(phase);
    if (squeeze)
      hold_off_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 2)
        drain_rows(0);
      offer_code(pick_code());
    end
  endtask

  initial begin
    code_ch.valid     = 1'b0;
    code_ch.codepoint = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    sender_idle_pct   = 0;
    recv_stall_pct    = 0;
    hold_off_req      = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values of the registers, then the hand-picked glyphs under them
    apb_access(1'b0, ADDR_CELL_WIDTH, '0);
    apb_access(1'b0, ADDR_CELL_HEIGHT, '0);
    apb_access(1'b0, ADDR_DPI, '0);
    set_idle(IDLE_NONE);
    for (int i = 0; i < 25; i++)
      offer_code(probe_codes[i]);

    // extremes: largest cell with thickest strokes, smallest cell,
    // zero sizes and zero resolution, sizes above the maximum
    run_batch(64, 64, 1023, 6, IDLE_SENDER, 1'b0);
    run_batch(1, 1, 1, 30, IDLE_RECEIVER, 1'b0);
    run_batch(0, 0, 0, 20, IDLE_BOTH, 1'b0);
    run_batch(127, 127, 1023, 4, IDLE_NONE, 1'b0);

    // random settings, small cells mostly, resolutions over the whole range
    for (int k = 0; k < 8; k++)
      run_batch(int'($urandom_range(1, 24)), int'($urandom_range(1, 24)),
                int'($urandom_range(0, 1023)), 30, k % 4, 1'b0);

    // back-pressure: the block fills up behind a stalled receiver
    run_batch(8, 12, 200, 40, IDLE_NONE, 1'b1);

    drain_rows(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
